>>> design/tkfp_pkg.sv
// shared types, constants and helpers for the touch and key frame parser
package tkfp_pkg;

	localparam int COORD_W = 12;
	localparam int DIV_W = 2 * COORD_W;
	localparam int VALUE_W = 16;
	localparam int FRAME_LEN = 12;
	localparam int COUNT_W = $clog2(FRAME_LEN + 1);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RESET = 12'd800;
	localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;
	localparam logic [COORD_W-1:0] PRESSURE_FULL = 12'hFFF;

	localparam logic CFG_SCREEN_WIDTH = 1'b0;
	localparam logic CFG_SCREEN_HEIGHT = 1'b1;

	localparam logic [7:0] TOUCH_HDR0 = 8'hFF;
	localparam logic [7:0] TOUCH_HDR1 = 8'h55;
	localparam logic [7:0] TOUCH_HDR2 = 8'h09;
	localparam logic [7:0] TOUCH_TYPE = 8'h05;
	localparam logic [7:0] TOUCH_LIFT = 8'h03;
	localparam logic [7:0] KEY_HDR0 = 8'h2E;
	localparam logic [7:0] KEY_HDR1 = 8'h06;
	localparam logic [7:0] KEY_HDR2 = 8'h02;
	localparam logic [7:0] KEY_TURN_A = 8'h31;
	localparam logic [7:0] KEY_TURN_B = 8'h32;

	localparam logic [2:0] EV_ABS_X = 3'd0;
	localparam logic [2:0] EV_ABS_Y = 3'd1;
	localparam logic [2:0] EV_PRESSURE = 3'd2;
	localparam logic [2:0] EV_SYNC = 3'd3;
	localparam logic [2:0] EV_KEY = 3'd4;

	localparam logic [1:0] JOB_TOUCH = 2'd0;
	localparam logic [1:0] JOB_LIFT = 2'd1;
	localparam logic [1:0] JOB_KEY = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] max_y;
		logic [7:0] key;
		logic [7:0] status;
	} job_t;

	function automatic logic key_mapped(input logic [7:0] k);
		return (k >= 8'h03 && k <= 8'h0F) || (k >= 8'h12 && k <= 8'h15) ||
			k == KEY_TURN_A || k == KEY_TURN_B;
	endfunction

endpackage

>>> design/touch_and_key_frame_parser.sv
// top level of the touch and key frame parser
//
// s_* channel: one serial byte per request; s_tuser high marks an empty
// read, which drops any partial frame. Bytes are taken one per cycle while
// the job queue has room; a completed valid frame becomes one queued job.
// m_* channel: one event per request, kind in m_tuser, value and key
// status in m_tdata, m_tlast on the last event of a frame.
// A touch frame gives X, Y, pressure and sync; each coordinate goes
// through a 12x12 multiply and a 24-step restoring divide. The sequencer
// holds while m_tready is low; the queue then fills and s_tready drops.
// cfg_* channel: always ready; index 0 screen width, 1 screen height, to be
// written only while no frame is in flight; the block does not enforce this.
// Reset clears the partial frame, the queue, the latched panel maxima and
// loads screen size 800 x 480.
module touch_and_key_frame_parser #(
	parameter int QUEUE_DEPTH = tkfp_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // rx_byte
	input  logic s_tuser,         // no_data
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,  // event_value [15:0], key_state [23:16]
	output logic [2:0] m_tuser,   // event_kind
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [tkfp_pkg::COORD_W-1:0] cfg_data
);

	logic [tkfp_pkg::COORD_W-1:0] screen_width_q;
	logic [tkfp_pkg::COORD_W-1:0] screen_height_q;
	logic accept;
	logic push;
	tkfp_pkg::job_t push_job;
	logic pop;
	tkfp_pkg::job_t head;
	logic q_empty;
	logic q_full;
	logic [tkfp_pkg::VALUE_W-1:0] event_value;
	logic [7:0] key_state;

	assign cfg_ready = 1'b1;
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign m_tdata = {key_state, event_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= tkfp_pkg::SCREEN_WIDTH_RESET;
			screen_height_q <= tkfp_pkg::SCREEN_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tkfp_pkg::CFG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				default: screen_height_q <= cfg_data;
			endcase
		end
	end

	tkfp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(s_tdata),
		.no_data(s_tuser),
		.push(push),
		.push_job(push_job)
	);

	tkfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	tkfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(head),
		.q_pop(pop),
		.screen_width(screen_width_q),
		.screen_height(screen_height_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.event_kind(m_tuser),
		.event_value(event_value),
		.key_state(key_state),
		.last(m_tlast)
	);

endmodule

>>> design/tkfp_queue.sv
// short job queue between the frame parser and the event sequencer
module tkfp_queue #(
	parameter int DEPTH = tkfp_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tkfp_pkg::job_t push_job,
	input  logic pop,
	output tkfp_pkg::job_t head,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tkfp_pkg::job_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign empty = (fill_q == '0);
	assign full = (fill_q == CW'(DEPTH));
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> design/tkfp_front.sv
// byte intake, frame assembly, header and checksum checks, job issue
module tkfp_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [7:0] rx_byte,
	input  logic no_data,
	output logic push,
	output tkfp_pkg::job_t push_job
);

	localparam int N = tkfp_pkg::FRAME_LEN;
	localparam int CW = tkfp_pkg::COUNT_W;

	logic [7:0] store_q [N];
	logic [CW-1:0] count_q;
	logic [7:0] sum_t_q;
	logic [7:0] sum_k_q;
	logic latched_q;
	logic [tkfp_pkg::COORD_W-1:0] max_x_q;
	logic [tkfp_pkg::COORD_W-1:0] max_y_q;

	logic [7:0] v [N];
	logic [CW-1:0] idx;
	logic touch_end;
	logic touch_ok;
	logic key_end;
	logic key_ok;
	logic hdr_bad;
	logic [tkfp_pkg::COORD_W-1:0] new_max_x;
	logic [tkfp_pkg::COORD_W-1:0] new_max_y;

	assign idx = count_q;

	// frame as it stands once this byte is in
	always_comb begin
		for (int i = 0; i < N; i++) begin
			v[i] = (idx == CW'(i)) ? rx_byte : store_q[i];
		end
	end

	assign new_max_x = {v[9][7:4], v[8]};
	assign new_max_y = {v[9][3:0], v[10]};

	assign touch_end = (idx == CW'(N - 1));
	assign touch_ok = (sum_t_q == rx_byte) && v[0] == tkfp_pkg::TOUCH_HDR0 &&
		v[1] == tkfp_pkg::TOUCH_HDR1 && v[2] == tkfp_pkg::TOUCH_HDR2 &&
		v[3] == tkfp_pkg::TOUCH_TYPE;

	assign key_end = (idx == CW'(5)) && v[0] == tkfp_pkg::KEY_HDR0 &&
		v[1] == tkfp_pkg::KEY_HDR1 && v[2] == tkfp_pkg::KEY_HDR2;
	assign key_ok = (~sum_k_q == rx_byte) && tkfp_pkg::key_mapped(v[3]) &&
		(v[4] <= 8'd1 || v[3] == tkfp_pkg::KEY_TURN_A || v[3] == tkfp_pkg::KEY_TURN_B);

	always_comb begin
		priority if (idx == CW'(0)) begin
			hdr_bad = rx_byte != tkfp_pkg::TOUCH_HDR0 && rx_byte != tkfp_pkg::KEY_HDR0;
		end else if (idx == CW'(1)) begin
			hdr_bad = v[0] != tkfp_pkg::KEY_HDR0 && rx_byte != tkfp_pkg::TOUCH_HDR1;
		end else if (idx == CW'(2)) begin
			hdr_bad = v[0] != tkfp_pkg::KEY_HDR0 && rx_byte != tkfp_pkg::TOUCH_HDR2;
		end else begin
			hdr_bad = 1'b0;
		end
	end

	always_comb begin
		push = 1'b0;
		push_job.kind = tkfp_pkg::JOB_KEY;
		push_job.x = {v[6][7:4], v[5]};
		push_job.y = {v[6][3:0], v[7]};
		push_job.max_x = latched_q ? max_x_q : new_max_x;
		push_job.max_y = latched_q ? max_y_q : new_max_y;
		push_job.key = v[3];
		push_job.status = v[4];
		if (accept && !no_data) begin
			priority if (touch_end) begin
				push = touch_ok;
				push_job.kind = (v[4] == tkfp_pkg::TOUCH_LIFT) ?
					tkfp_pkg::JOB_LIFT : tkfp_pkg::JOB_TOUCH;
			end else if (key_end) begin
				push = key_ok;
			end else begin
				push = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !no_data) begin
			store_q[idx] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_t_q <= '0;
			sum_k_q <= '0;
			latched_q <= 1'b0;
			max_x_q <= '0;
			max_y_q <= '0;
		end else if (accept) begin
			if (no_data) begin
				count_q <= '0;
			end else begin
				// running checksums: touch over bytes 2..10, key over bytes 1..4
				if (idx == CW'(2)) begin
					sum_t_q <= rx_byte;
				end else if (idx > CW'(2) && idx <= CW'(10)) begin
					sum_t_q <= sum_t_q + rx_byte;
				end
				if (idx == CW'(1)) begin
					sum_k_q <= rx_byte;
				end else if (idx > CW'(1) && idx <= CW'(4)) begin
					sum_k_q <= sum_k_q + rx_byte;
				end
				if (touch_end && touch_ok && !latched_q) begin
					latched_q <= 1'b1;
					max_x_q <= new_max_x;
					max_y_q <= new_max_y;
				end
				if (touch_end || key_end || hdr_bad) begin
					count_q <= '0;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> design/tkfp_back.sv
// event sequencer with shared iterative scaler and output register
module tkfp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  tkfp_pkg::job_t q_head,
	output logic q_pop,
	input  logic [tkfp_pkg::COORD_W-1:0] screen_width,
	input  logic [tkfp_pkg::COORD_W-1:0] screen_height,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [2:0] event_kind,
	output logic [tkfp_pkg::VALUE_W-1:0] event_value,
	output logic [7:0] key_state,
	output logic last
);

	localparam int CW = tkfp_pkg::COORD_W;
	localparam int DW = tkfp_pkg::DIV_W;
	localparam int SW = $clog2(DW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [2:0] ev_q;
	tkfp_pkg::job_t job_q;
	logic [CW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic m_tvalid_q;

	logic out_free;
	logic [CW-1:0] coord;
	logic [CW-1:0] screen;
	logic [CW-1:0] divisor;
	logic [CW:0] trial;
	logic fits;
	logic [tkfp_pkg::VALUE_W-1:0] scaled;
	logic [tkfp_pkg::VALUE_W-1:0] value;

	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	assign coord = (ev_q == tkfp_pkg::EV_ABS_X) ? job_q.x : job_q.y;
	assign screen = (ev_q == tkfp_pkg::EV_ABS_X) ? screen_width : screen_height;
	assign divisor = (ev_q == tkfp_pkg::EV_ABS_X) ? job_q.max_x : job_q.max_y;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits = trial >= {1'b0, divisor};

	// zero panel maximum and overflow both saturate
	assign scaled = (divisor == '0 || quo_q[DW-1:tkfp_pkg::VALUE_W] != '0) ?
		'1 : quo_q[tkfp_pkg::VALUE_W-1:0];

	always_comb begin
		unique case (ev_q)
			tkfp_pkg::EV_ABS_X, tkfp_pkg::EV_ABS_Y: value = scaled;
			tkfp_pkg::EV_PRESSURE: value = (job_q.kind == tkfp_pkg::JOB_LIFT) ?
				'0 : tkfp_pkg::VALUE_W'(tkfp_pkg::PRESSURE_FULL);
			tkfp_pkg::EV_KEY: value = tkfp_pkg::VALUE_W'(job_q.key);
			default: value = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		unique case (state_q)
			ST_MUL: begin
				quo_q <= DW'(coord) * DW'(screen);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
				quo_q <= {quo_q[DW-2:0], fits};
			end
			default: begin
				rem_q <= rem_q;
				quo_q <= quo_q;
			end
		endcase
		if (state_q == ST_EMIT && out_free) begin
			event_kind <= ev_q;
			event_value <= value;
			key_state <= (ev_q == tkfp_pkg::EV_KEY) ? job_q.status : 8'd0;
			last <= (ev_q == tkfp_pkg::EV_SYNC) || (ev_q == tkfp_pkg::EV_KEY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ev_q <= tkfp_pkg::EV_ABS_X;
			step_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						unique case (q_head.kind)
							tkfp_pkg::JOB_TOUCH: begin
								ev_q <= tkfp_pkg::EV_ABS_X;
								state_q <= ST_MUL;
							end
							tkfp_pkg::JOB_LIFT: begin
								ev_q <= tkfp_pkg::EV_PRESSURE;
								state_q <= ST_EMIT;
							end
							default: begin
								ev_q <= tkfp_pkg::EV_KEY;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_MUL: begin
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(DW - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						unique case (ev_q)
							tkfp_pkg::EV_ABS_X: begin
								ev_q <= tkfp_pkg::EV_ABS_Y;
								state_q <= ST_MUL;
							end
							tkfp_pkg::EV_ABS_Y: ev_q <= tkfp_pkg::EV_PRESSURE;
							tkfp_pkg::EV_PRESSURE: ev_q <= tkfp_pkg::EV_SYNC;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/tkfp_checker.sv
// port-level checks for the touch and key frame parser, bound to the top
module tkfp_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic m_tlast
);

	// a stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("stalled event changed");

	// frames close on sync or key, and only there
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tlast == (m_tuser == tkfp_pkg::EV_SYNC || m_tuser == tkfp_pkg::EV_KEY))
		else $error("tlast does not match event kind");

	// pressure is either lifted or full
	a_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tkfp_pkg::EV_PRESSURE |->
		m_tdata[15:0] == 16'd0 || m_tdata[15:0] == 16'h0FFF)
		else $error("bad pressure value");

	// key status only travels with key events
	a_key_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != tkfp_pkg::EV_KEY |-> m_tdata[23:16] == 8'd0)
		else $error("key status on non-key event");

endmodule

bind touch_and_key_frame_parser tkfp_checker u_tkfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);

>>> bench/touch_and_key_frame_parser_tb.sv
// self-checking bench for the touch and key frame parser: byte stream in, input events out
module touch_and_key_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_CYCLES = 100;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_BYTES = 44;

	typedef struct {
		logic [7:0] data;
		logic no_data;
	} rx_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] value;
		logic [7:0] kstate;
		logic last;
	} event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = tkfp_pkg::CFG_SCREEN_WIDTH;
	logic [tkfp_pkg::COORD_W-1:0] cfg_data = '0;

	rx_item_t rx_backlog[$];
	event_t events_due[$];
	int bytes_queued = 0;

	// own copy of the parser state
	logic [7:0] frame_buf [tkfp_pkg::FRAME_LEN];
	int frame_fill = 0;
	bit maxima_held = 1'b0;
	logic [tkfp_pkg::COORD_W-1:0] pmax_x = '0;
	logic [tkfp_pkg::COORD_W-1:0] pmax_y = '0;
	logic [tkfp_pkg::COORD_W-1:0] scr_w = tkfp_pkg::SCREEN_WIDTH_RESET;
	logic [tkfp_pkg::COORD_W-1:0] scr_h = tkfp_pkg::SCREEN_HEIGHT_RESET;

	bit byte_taken = 1'b0;
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int send_gap = 0;
	int hold_left = 0;
	int fault_count = 0;
	int quiet_cycles = 0;
	rx_item_t cur;
	event_t got, want;
	logic [tkfp_pkg::COORD_W-1:0] panel_x_full;

	touch_and_key_frame_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),    // rx_byte
		.s_tuser(s_tuser),    // no_data
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),    // event_value [15:0], key_state [23:16]
		.m_tuser(m_tuser),    // event_kind
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] scaled(logic [tkfp_pkg::COORD_W-1:0] coord,
			logic [tkfp_pkg::COORD_W-1:0] scr, logic [tkfp_pkg::COORD_W-1:0] pmax);
		logic [tkfp_pkg::DIV_W-1:0] prod;
		logic [tkfp_pkg::DIV_W-1:0] q;
		if (pmax == '0)
			return 16'hFFFF;
		prod = coord * scr;
		q = prod / pmax;
		return (q > 24'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic bit has_keycode(logic [7:0] k);
		return (k >= 8'h03 && k <= 8'h0F) || (k >= 8'h12 && k <= 8'h15) ||
			k == tkfp_pkg::KEY_TURN_A || k == tkfp_pkg::KEY_TURN_B;
	endfunction

	function automatic void add_event(logic [2:0] kind, logic [15:0] value, logic [7:0] ks);
		events_due.push_back('{kind, value, ks, 1'b0});
	endfunction

	function automatic void close_touch();
		logic [7:0] sum;
		logic [tkfp_pkg::COORD_W-1:0] cx, cy;
		sum = 8'h00;
		for (int i = 2; i < 11; i++)
			sum = sum + frame_buf[i];
		if (sum != frame_buf[11] || frame_buf[0] != tkfp_pkg::TOUCH_HDR0 ||
				frame_buf[1] != tkfp_pkg::TOUCH_HDR1 ||
				frame_buf[2] != tkfp_pkg::TOUCH_HDR2 ||
				frame_buf[3] != tkfp_pkg::TOUCH_TYPE)
			return;
		if (!maxima_held) begin
			pmax_x = {frame_buf[9][7:4], frame_buf[8]};
			pmax_y = {frame_buf[9][3:0], frame_buf[10]};
			maxima_held = 1'b1;
		end
		if (frame_buf[4] == tkfp_pkg::TOUCH_LIFT) begin
			add_event(tkfp_pkg::EV_PRESSURE, 16'h0000, 8'h00);
			add_event(tkfp_pkg::EV_SYNC, 16'h0000, 8'h00);
			return;
		end
		cx = {frame_buf[6][7:4], frame_buf[5]};
		cy = {frame_buf[6][3:0], frame_buf[7]};
		add_event(tkfp_pkg::EV_ABS_X, scaled(cx, scr_w, pmax_x), 8'h00);
		add_event(tkfp_pkg::EV_ABS_Y, scaled(cy, scr_h, pmax_y), 8'h00);
		add_event(tkfp_pkg::EV_PRESSURE, {4'h0, tkfp_pkg::PRESSURE_FULL}, 8'h00);
		add_event(tkfp_pkg::EV_SYNC, 16'h0000, 8'h00);
	endfunction

	function automatic void close_key();
		logic [7:0] sum;
		logic [7:0] k, st;
		k = frame_buf[3];
		st = frame_buf[4];
		sum = frame_buf[1] + frame_buf[2] + frame_buf[3] + frame_buf[4];
		sum = ~sum;
		if (sum != frame_buf[5] || !has_keycode(k))
			return;
		if (st > 8'd1 && k != tkfp_pkg::KEY_TURN_A && k != tkfp_pkg::KEY_TURN_B)
			return;
		add_event(tkfp_pkg::EV_KEY, {8'h00, k}, st);
	endfunction

	function automatic void absorb_byte(logic [7:0] b, logic nd);
		int n_prior;
		n_prior = events_due.size();
		if (nd) begin
			frame_fill = 0;
			return;
		end
		frame_buf[frame_fill] = b;
		frame_fill++;
		if (frame_fill == tkfp_pkg::FRAME_LEN) begin
			close_touch();
			frame_fill = 0;
		end else if (frame_buf[0] == tkfp_pkg::KEY_HDR0) begin
			if (frame_fill >= 6 && frame_buf[1] == tkfp_pkg::KEY_HDR1 &&
					frame_buf[2] == tkfp_pkg::KEY_HDR2) begin
				close_key();
				frame_fill = 0;
			end
		end else if (frame_buf[0] != tkfp_pkg::TOUCH_HDR0 ||
				(frame_fill > 1 && frame_buf[1] != tkfp_pkg::TOUCH_HDR1) ||
				(frame_fill > 2 && frame_buf[2] != tkfp_pkg::TOUCH_HDR2)) begin
			frame_fill = 0;
		end
		if (events_due.size() > n_prior)
			events_due[events_due.size()-1].last = 1'b1;
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	// request sampling, prediction, checking and the watchdog
	always @(posedge clk) begin
		byte_taken = s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[15:0], m_tdata[23:16], m_tlast};
				if (events_due.size() == 0) begin
					note_fault($sformatf("unexpected event: kind %0d value %h state %h last %b",
						got.kind, got.value, got.kstate, got.last));
				end else begin
					want = events_due.pop_front();
					if (got.kind !== want.kind || got.value !== want.value ||
							got.kstate !== want.kstate || got.last !== want.last)
						note_fault($sformatf({"event mismatch: got kind %0d value %h state %h ",
							"last %b, expected kind %0d value %h state %h last %b"},
							got.kind, got.value, got.kstate, got.last,
							want.kind, want.value, want.kstate, want.last));
				end
			end
			if (byte_taken)
				absorb_byte(s_tdata, s_tuser);
			if (byte_taken || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// byte sender
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || byte_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!calm && rx_backlog.size() != 0 && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 12);
				s_tvalid <= 1'b0;
			end else if (rx_backlog.size() != 0) begin
				cur = rx_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= cur.data;
				s_tuser <= cur.no_data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// event receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [7:0] any_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [tkfp_pkg::COORD_W-1:0] any_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return tkfp_pkg::COORD_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic void queue_byte(logic [7:0] b, logic nd = 1'b0);
		rx_backlog.push_back('{b, nd});
		bytes_queued++;
	endfunction

	function automatic void queue_empty();
		queue_byte(any_byte(), 1'b1);
	endfunction

	// keep < 12 cuts the frame short with an empty read
	function automatic void queue_touch(logic [7:0] ftype, logic [7:0] code,
			logic [tkfp_pkg::COORD_W-1:0] x, logic [tkfp_pkg::COORD_W-1:0] y,
			logic [tkfp_pkg::COORD_W-1:0] mx, logic [tkfp_pkg::COORD_W-1:0] my,
			bit bad_sum, int keep);
		logic [7:0] f [tkfp_pkg::FRAME_LEN];
		logic [7:0] sum;
		f[0] = tkfp_pkg::TOUCH_HDR0;
		f[1] = tkfp_pkg::TOUCH_HDR1;
		f[2] = tkfp_pkg::TOUCH_HDR2;
		f[3] = ftype;
		f[4] = code;
		f[5] = x[7:0];
		f[6] = {x[11:8], y[11:8]};
		f[7] = y[7:0];
		f[8] = mx[7:0];
		f[9] = {mx[11:8], my[11:8]};
		f[10] = my[7:0];
		sum = 8'h00;
		for (int i = 2; i < 11; i++)
			sum = sum + f[i];
		f[11] = bad_sum ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum;
		for (int i = 0; i < keep; i++)
			queue_byte(f[i]);
		if (keep < tkfp_pkg::FRAME_LEN)
			queue_empty();
	endfunction

	function automatic void queue_key(logic [7:0] k, logic [7:0] st, bit bad_sum,
			logic [7:0] h1, logic [7:0] h2);
		logic [7:0] sum;
		sum = h1 + h2 + k + st;
		sum = ~sum;
		if (bad_sum)
			sum = sum ^ (8'h01 << $urandom_range(0, 7));
		queue_byte(tkfp_pkg::KEY_HDR0);
		queue_byte(h1);
		queue_byte(h2);
		queue_byte(k);
		queue_byte(st);
		queue_byte(sum);
	endfunction

	function automatic logic [7:0] pick_key();
		case ($urandom_range(0, 9))
			0: return any_byte();
			1: return tkfp_pkg::KEY_TURN_A;
			2: return tkfp_pkg::KEY_TURN_B;
			3, 4: return 8'($urandom_range(8'h12, 8'h15));
			default: return 8'($urandom_range(8'h03, 8'h0F));
		endcase
	endfunction

	function automatic logic [7:0] pick_status();
		return ($urandom_range(0, 2) == 0) ? any_byte() : 8'($urandom_range(0, 1));
	endfunction

	function automatic void fill_random(int budget);
		int goal;
		int sel;
		goal = bytes_queued + budget;
		while (bytes_queued < goal) begin
			sel = $urandom_range(0, 19);
			if (sel < 8) begin
				queue_touch(tkfp_pkg::TOUCH_TYPE,
					($urandom_range(0, 4) == 0) ? tkfp_pkg::TOUCH_LIFT : any_byte(),
					any_coord(), any_coord(), any_coord(), any_coord(), 1'b0,
					tkfp_pkg::FRAME_LEN);
			end else if (sel < 13) begin
				queue_key(pick_key(), pick_status(), 1'b0, tkfp_pkg::KEY_HDR1,
					tkfp_pkg::KEY_HDR2);
			end else if (sel == 13) begin
				queue_touch(tkfp_pkg::TOUCH_TYPE, any_byte(), any_coord(), any_coord(),
					any_coord(), any_coord(), 1'b1, tkfp_pkg::FRAME_LEN);
			end else if (sel == 14) begin
				queue_touch(any_byte(), any_byte(), any_coord(), any_coord(), any_coord(),
					any_coord(), 1'b0, tkfp_pkg::FRAME_LEN);
			end else if (sel == 15) begin
				queue_touch(tkfp_pkg::TOUCH_TYPE, any_byte(), any_coord(), any_coord(),
					any_coord(), any_coord(), 1'b0, $urandom_range(1, 11));
			end else if (sel == 16) begin
				// broken touch header
				queue_byte(tkfp_pkg::TOUCH_HDR0);
				if ($urandom_range(0, 1))
					queue_byte(tkfp_pkg::TOUCH_HDR1);
				queue_byte(any_byte());
				if ($urandom_range(0, 1))
					queue_empty();
			end else if (sel == 17) begin
				if ($urandom_range(0, 1))
					queue_key(pick_key(), pick_status(), 1'b1, tkfp_pkg::KEY_HDR1,
						tkfp_pkg::KEY_HDR2);
				else
					queue_key(pick_key(), pick_status(), 1'b0, any_byte(), any_byte());
			end else if (sel == 18) begin
				repeat ($urandom_range(1, 3))
					queue_byte(any_byte());
				if ($urandom_range(0, 1))
					queue_empty();
			end else begin
				queue_empty();
			end
		end
	endfunction

	task automatic write_reg(input logic idx, input logic [tkfp_pkg::COORD_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == tkfp_pkg::CFG_SCREEN_WIDTH)
			scr_w = val;
		else
			scr_h = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (rx_backlog.size() != 0 || s_tvalid || events_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the lift frame below is the first good touch frame and fixes the panel maxima;
		// a zero maximum Y keeps Y saturated for the whole run
		panel_x_full = tkfp_pkg::COORD_W'($urandom_range(200, 400));
		queue_byte(8'h00, 1'b1);
		queue_key(tkfp_pkg::KEY_TURN_A, 8'hFF, 1'b0, tkfp_pkg::KEY_HDR1, tkfp_pkg::KEY_HDR2);
		queue_touch(tkfp_pkg::TOUCH_TYPE, tkfp_pkg::TOUCH_LIFT, 12'hFFF, 12'h000,
			panel_x_full, 12'h000, 1'b0, tkfp_pkg::FRAME_LEN);
		queue_key(8'h00, 8'h01, 1'b0, tkfp_pkg::KEY_HDR1, tkfp_pkg::KEY_HDR2);
		fill_random(PHASE_BYTES);
		settle();

		write_reg(tkfp_pkg::CFG_SCREEN_WIDTH, 12'hFFF);
		write_reg(tkfp_pkg::CFG_SCREEN_HEIGHT, 12'hFFF);
		fill_random(PHASE_BYTES);
		long_hold_req = 1'b1;
		settle();

		write_reg(tkfp_pkg::CFG_SCREEN_WIDTH, 12'h001);
		write_reg(tkfp_pkg::CFG_SCREEN_HEIGHT, 12'h001);
		fill_random(PHASE_BYTES);
		settle();

		write_reg(tkfp_pkg::CFG_SCREEN_WIDTH, 12'h000);
		write_reg(tkfp_pkg::CFG_SCREEN_HEIGHT, tkfp_pkg::COORD_W'($urandom_range(1, 4095)));
		fill_random(PHASE_BYTES);
		settle();

		write_reg(tkfp_pkg::CFG_SCREEN_WIDTH, tkfp_pkg::COORD_W'($urandom_range(1, 4095)));
		write_reg(tkfp_pkg::CFG_SCREEN_HEIGHT, 12'h000);
		fill_random(PHASE_BYTES);
		settle();

		// closing stretch with no idling on either side
		calm = 1'b1;
		write_reg(tkfp_pkg::CFG_SCREEN_WIDTH, tkfp_pkg::COORD_W'($urandom_range(1, 4095)));
		write_reg(tkfp_pkg::CFG_SCREEN_HEIGHT, tkfp_pkg::COORD_W'($urandom_range(1, 4095)));
		fill_random(PHASE_BYTES);
		settle();

		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
